@@ sv/jspfe_pkg.sv @@
// ----------------------------------------------------------------------------
// jspfe_pkg
// Shared widths, constants and the queue entry type of the joint step-period
// frame encoder.
// ----------------------------------------------------------------------------
package jspfe_pkg;

  localparam int NUM_JOINTS_DEF  = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int JOINT_W    = 3;
  localparam int SPEED_W    = 24;
  localparam int ANGLE_W    = 24;
  localparam int GEAR_W     = 12;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_W      = SPEED_W + GEAR_W;
  localparam int NUMER_W    = 26;
  localparam int PERIOD_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int FRAME_LEN  = 6;
  localparam int POS_W      = 3;

  // register map: indexes 0..5 are the per-joint gear ratios
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 3'd6;

  localparam logic [GEAR_W-1:0]   GEAR_RESET        = 12'd1;
  localparam logic [MASK_W-1:0]   MASK_RESET        = 6'd3;
  // 42e6 * 2 * pi / 6000, scaled by 1024
  localparam logic [NUMER_W-1:0]  PERIOD_NUMERATOR  = 26'd45037872;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX        = 16'hFFFF;
  localparam logic [BYTE_W-1:0]   FRAME_HEAD        = 8'h66;
  localparam logic [BYTE_W-1:0]   FRAME_CHECK       = 8'h11;
  localparam logic [BYTE_W-1:0]   FRAME_TAIL        = 8'h88;

  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    logic             dir;
  } job_t;

endpackage

@@ sv/jspfe_front.sv @@
// ----------------------------------------------------------------------------
// jspfe_front
// Takes joint updates, holds the configuration registers and per-joint angle
// state, resolves direction and forms the divisor |speed| * gear ratio.
// ----------------------------------------------------------------------------
module jspfe_front #(
  parameter int NUM_JOINTS = jspfe_pkg::NUM_JOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [jspfe_pkg::JOINT_W-1:0]       in_joint_number,
  input  logic signed [jspfe_pkg::SPEED_W-1:0] in_joint_speed,
  input  logic signed [jspfe_pkg::ANGLE_W-1:0] in_joint_angle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jspfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jspfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                push,
  output jspfe_pkg::job_t                     push_job,
  input  logic                                q_full
);
  import jspfe_pkg::*;

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  logic [GEAR_W-1:0]         gear_r [NUM_JOINTS];
  logic [NUM_JOINTS-1:0]     mask_r;
  logic signed [ANGLE_W-1:0] prev_angle_r [NUM_JOINTS];
  logic [NUM_JOINTS-1:0]     moving_up_r;
  logic [NUM_JOINTS-1:0]     seen_r;

  logic              s1_valid_r;
  logic [SPEED_W-1:0] mag_r;
  logic [GEAR_W-1:0]  gear_s_r;
  logic               dir_r;

  logic               in_accept;
  logic               joint_ok;
  logic [JW-1:0]      jidx;
  logic               up_nxt;
  logic [SPEED_W-1:0] mag_nxt;

  assign cfg_ready = 1'b1;
  assign push      = s1_valid_r && !q_full;
  assign in_stall  = s1_valid_r && q_full;
  assign in_accept = in_valid && !in_stall;
  assign joint_ok  = {1'b0, in_joint_number} < (JOINT_W + 1)'(NUM_JOINTS);
  assign jidx      = in_joint_number[JW-1:0];

  assign push_job.divisor = mag_r * gear_s_r;
  assign push_job.dir     = dir_r;

  // two's complement magnitude; the most negative speed maps to 2^23
  assign mag_nxt = in_joint_speed[SPEED_W-1] ? SPEED_W'(-in_joint_speed)
                                              : SPEED_W'(in_joint_speed);

  always_comb begin
    up_nxt = moving_up_r[jidx];
    if (seen_r[jidx]) begin
      if (in_joint_angle > prev_angle_r[jidx]) begin
        up_nxt = 1'b1;
      end else if (in_joint_angle < prev_angle_r[jidx]) begin
        up_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        gear_r[j]       <= GEAR_RESET;
        prev_angle_r[j] <= '0;
      end
      mask_r      <= MASK_RESET[NUM_JOINTS-1:0];
      moving_up_r <= '0;
      seen_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_IDX_W'(NUM_JOINTS)) begin
          gear_r[cfg_index[JW-1:0]] <= cfg_data[GEAR_W-1:0];
        end else if (cfg_index == CFG_IDX_MASK) begin
          mask_r <= cfg_data[NUM_JOINTS-1:0];
        end
      end
      if (in_accept && joint_ok) begin
        prev_angle_r[jidx] <= in_joint_angle;
        moving_up_r[jidx]  <= up_nxt;
        seen_r[jidx]       <= 1'b1;
        s1_valid_r         <= 1'b1;
        mag_r              <= mag_nxt;
        gear_s_r           <= gear_r[jidx];
        dir_r              <= up_nxt ^ mask_r[jidx];
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ sv/jspfe_queue.sv @@
// ----------------------------------------------------------------------------
// jspfe_queue
// Short FIFO of pending division jobs between front and back.
// ----------------------------------------------------------------------------
module jspfe_queue #(
  parameter int DEPTH = jspfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jspfe_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output jspfe_pkg::job_t pop_job,
  output logic            empty
);
  import jspfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count_r <= count_r + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/jspfe_back.sv @@
// ----------------------------------------------------------------------------
// jspfe_back
// Restoring divider for the step period, then serializes the six-byte frame.
// ----------------------------------------------------------------------------
module jspfe_back (
  input  logic                           clk,
  input  logic                           rst_n,
  output logic                           pop,
  input  jspfe_pkg::job_t                pop_job,
  input  logic                           q_empty,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [jspfe_pkg::BYTE_W-1:0]   out_frame_byte,
  output logic                           out_frame_last
);
  import jspfe_pkg::*;

  localparam int CNT_W = $clog2(NUMER_W);
  localparam logic [POS_W-1:0] POS_HEAD  = 3'd0;
  localparam logic [POS_W-1:0] POS_LO    = 3'd1;
  localparam logic [POS_W-1:0] POS_HI    = 3'd2;
  localparam logic [POS_W-1:0] POS_DIR   = 3'd3;
  localparam logic [POS_W-1:0] POS_CHECK = 3'd4;
  localparam logic [POS_W-1:0] POS_TAIL  = 3'd5;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SEND} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [NUMER_W-1:0]  div_r;
  logic [NUMER_W-1:0]  rem_r;
  logic [NUMER_W-1:0]  quo_r;
  logic [PERIOD_W-1:0] period_r;
  logic                dir_r;
  logic [POS_W-1:0]    pos_r;

  logic [NUMER_W:0]    trial;
  logic [NUMER_W:0]    diff;
  logic                ge;
  logic [NUMER_W-1:0]  quo_nxt;
  logic                no_div;

  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = state_r == ST_SEND;

  assign trial   = {rem_r, PERIOD_NUMERATOR[cnt_r]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = trial >= {1'b0, div_r};
  assign quo_nxt = {quo_r[NUMER_W-2:0], ge};
  // divisor zero, or larger than the numerator (quotient zero): saturate
  assign no_div  = (pop_job.divisor == '0) ||
                   (pop_job.divisor > DIV_W'(PERIOD_NUMERATOR));

  always_comb begin
    out_frame_last = pos_r == POS_TAIL;
    case (pos_r)
      POS_HEAD:  out_frame_byte = FRAME_HEAD;
      POS_LO:    out_frame_byte = period_r[BYTE_W-1:0];
      POS_HI:    out_frame_byte = period_r[PERIOD_W-1:BYTE_W];
      POS_DIR:   out_frame_byte = {{(BYTE_W-1){1'b0}}, dir_r};
      POS_CHECK: out_frame_byte = FRAME_CHECK;
      POS_TAIL:  out_frame_byte = FRAME_TAIL;
      default:   out_frame_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= POS_HEAD;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            dir_r <= pop_job.dir;
            pos_r <= POS_HEAD;
            if (no_div) begin
              period_r <= PERIOD_MAX;
              state_r  <= ST_SEND;
            end else begin
              div_r   <= pop_job.divisor[NUMER_W-1:0];
              rem_r   <= '0;
              quo_r   <= '0;
              cnt_r   <= CNT_W'(NUMER_W - 1);
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_r <= ge ? diff[NUMER_W-1:0] : trial[NUMER_W-1:0];
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (quo_nxt == '0 || quo_nxt > NUMER_W'(PERIOD_MAX)) begin
              period_r <= PERIOD_MAX;
            end else begin
              period_r <= quo_nxt[PERIOD_W-1:0];
            end
            state_r <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!out_stall) begin
            if (pos_r == POS_TAIL) begin
              state_r <= ST_IDLE;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // restoring division keeps the partial remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_tail_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_frame_last) |=> (state_r == ST_IDLE))
    else $error("frame did not end after trailer");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_DIV || state_r == ST_SEND))
    else $error("dequeued job not started");

endmodule

@@ sv/joint_step_period_frame_encoder_unit.sv @@
// Joint step-period frame encoder. Each accepted joint update (joint number,
// signed speed in 1/1024 rad/s, angle in 1e-4 rad) produces the six-byte frame
// 0x66, period low, period high, direction, 0x11, 0x88 on the out_ channel,
// frame_last marking the trailer. The period is floor(45037872 / (|speed| *
// gear ratio)), forced to 65535 when the divisor is zero or the quotient is
// zero or above 65535. Updates whose joint number is not below NUM_JOINTS are
// taken and dropped without output. A normal update occupies the back end for
// a dequeue step, the bit-serial restoring divider over a 26-bit quotient and
// the six frame bytes, plus any output stall; a saturated period skips the
// divider. The front end and a QUEUE_DEPTH-entry job queue keep taking
// updates while a frame is still being sent. cfg_ready is always high;
// configuration is meant to be written while no frame is pending.
// ----------------------------------------------------------------------------
// joint_step_period_frame_encoder_unit
// Top level: front end, job queue and divider/serializer back end.
// ----------------------------------------------------------------------------
module joint_step_period_frame_encoder_unit #(
  parameter int NUM_JOINTS  = jspfe_pkg::NUM_JOINTS_DEF,
  parameter int QUEUE_DEPTH = jspfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [jspfe_pkg::JOINT_W-1:0]        in_joint_number,
  input  logic signed [jspfe_pkg::SPEED_W-1:0] in_joint_speed,
  input  logic signed [jspfe_pkg::ANGLE_W-1:0] in_joint_angle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [jspfe_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic                                 out_frame_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jspfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jspfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jspfe_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t pop_job;
  logic q_empty;

  jspfe_front #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_joint_number(in_joint_number),
    .in_joint_speed (in_joint_speed),
    .in_joint_angle (in_joint_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .push_job       (push_job),
    .q_full         (q_full)
  );

  jspfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  jspfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop           (pop),
    .pop_job       (pop_job),
    .q_empty       (q_empty),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last)
  );

endmodule

@@ verif/jspfe_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jspfe_frame_checker
// Passive checker for the joint step-period frame encoder: it tracks the
// register writes, predicts the six-byte frame of every accepted joint update
// and compares each accepted output transaction against the oldest pending
// frame byte.
// ----------------------------------------------------------------------------
module jspfe_frame_checker #(
  parameter int NUM_JOINTS = jspfe_pkg::NUM_JOINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [jspfe_pkg::JOINT_W-1:0]        in_joint_number,
  input  logic signed [jspfe_pkg::SPEED_W-1:0] in_joint_speed,
  input  logic signed [jspfe_pkg::ANGLE_W-1:0] in_joint_angle,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [jspfe_pkg::BYTE_W-1:0]         out_frame_byte,
  input  logic                                 out_frame_last,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [jspfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jspfe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   beats_pending
);
  import jspfe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  frame_beat_t               frame_fifo[$];
  logic [GEAR_W-1:0]         gear_ratio [NUM_JOINTS_DEF];
  logic [MASK_W-1:0]         invert_mask;
  logic signed [ANGLE_W-1:0] last_angle [NUM_JOINTS_DEF];
  logic                      heading_up [NUM_JOINTS_DEF];
  logic                      angle_known [NUM_JOINTS_DEF];

  function automatic logic [PERIOD_W-1:0] step_period(
    input logic signed [SPEED_W-1:0] speed,
    input logic [GEAR_W-1:0]         ratio
  );
    longint mag;
    longint divisor;
    longint quot;
    mag = speed;
    if (mag < 0) mag = -mag;
    divisor = mag * longint'(ratio);
    if (divisor == 0) return PERIOD_MAX;
    quot = longint'(PERIOD_NUMERATOR) / divisor;
    if (quot == 0 || quot > longint'(PERIOD_MAX)) return PERIOD_MAX;
    return PERIOD_W'(quot);
  endfunction

  function automatic void push_beat(input logic [BYTE_W-1:0] data, input logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    frame_fifo.push_back(beat);
  endfunction

  function automatic void encode_update(
    input logic [JOINT_W-1:0]        joint,
    input logic signed [SPEED_W-1:0] speed,
    input logic signed [ANGLE_W-1:0] angle
  );
    logic [PERIOD_W-1:0] period;
    logic                dir;
    // out-of-range joints are swallowed without a frame
    if (joint >= NUM_JOINTS) return;
    period = step_period(speed, gear_ratio[joint]);
    if (angle_known[joint]) begin
      if (angle > last_angle[joint]) heading_up[joint] = 1'b1;
      else if (angle < last_angle[joint]) heading_up[joint] = 1'b0;
    end
    last_angle[joint]  = angle;
    angle_known[joint] = 1'b1;
    dir = heading_up[joint] ^ invert_mask[joint];
    push_beat(FRAME_HEAD, 1'b0);
    push_beat(period[7:0], 1'b0);
    push_beat(period[15:8], 1'b0);
    push_beat({7'd0, dir}, 1'b0);
    push_beat(FRAME_CHECK, 1'b0);
    push_beat(FRAME_TAIL, 1'b1);
  endfunction

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      for (int j = 0; j < NUM_JOINTS_DEF; j++) begin
        gear_ratio[j]  = GEAR_RESET;
        last_angle[j]  = '0;
        heading_up[j]  = 1'b0;
        angle_known[j] = 1'b0;
      end
      invert_mask = MASK_RESET;
      frame_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_IDX_MASK) gear_ratio[cfg_index] = cfg_data[GEAR_W-1:0];
        else if (cfg_index == CFG_IDX_MASK) invert_mask = cfg_data[MASK_W-1:0];
      end
      if (in_valid && !in_stall)
        encode_update(in_joint_number, in_joint_speed, in_joint_angle);
      if (out_valid && !out_stall) begin
        if (frame_fifo.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction: expected none, actual byte %02h last %0b",
                   $time, out_frame_byte, out_frame_last);
        end else begin
          want = frame_fifo.pop_front();
          if (out_frame_byte !== want.data) begin
            fail_count++;
            $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_frame_byte);
          end
          if (out_frame_last !== want.last) begin
            fail_count++;
            $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_frame_last);
          end
        end
      end
    end
    beats_pending = frame_fifo.size();
  end

endmodule

@@ verif/joint_step_period_frame_encoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_step_period_frame_encoder_unit_tb
// Drives joint updates and register writes into the frame encoder: a directed
// pass over speed/angle corners and gear/mask extremes, then random phases,
// all but the last under random backpressure; the frame checker scores the output.
// ----------------------------------------------------------------------------
module joint_step_period_frame_encoder_unit_tb;
  import jspfe_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GEAR0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [JOINT_W-1:0]        in_joint_number = '0;
  logic signed [SPEED_W-1:0] in_joint_speed = '0;
  logic signed [ANGLE_W-1:0] in_joint_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [BYTE_W-1:0]         out_frame_byte;
  logic                      out_frame_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int fail_count;
  int beats_pending;
  int cycle_count;
  bit idle_on = 1'b1;
  int hold_reqs = 0;
  int holds_served = 0;
  // last angle sent per joint number, used to shape near-miss angle changes
  logic signed [ANGLE_W-1:0] sent_angle [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  joint_step_period_frame_encoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_joint_number(in_joint_number), .in_joint_speed(in_joint_speed),
    .in_joint_angle(in_joint_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_byte(out_frame_byte), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  jspfe_frame_checker frame_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_joint_number(in_joint_number), .in_joint_speed(in_joint_speed),
    .in_joint_angle(in_joint_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_byte(out_frame_byte), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .beats_pending(beats_pending)
  );

  // output side backpressure: random bursts plus the requested long hold
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served < hold_reqs) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL joint_step_period_frame_encoder_unit");
    $finish;
  end

  // Starts and ends on a rising edge; valid stays high for a back-to-back item.
  task automatic send_update(
    input logic [JOINT_W-1:0]        joint,
    input logic signed [SPEED_W-1:0] speed,
    input logic signed [ANGLE_W-1:0] angle
  );
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_joint_number <= joint;
    in_joint_speed  <= speed;
    in_joint_angle  <= angle;
    sent_angle[joint] = angle;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Wait for every frame byte, then let a dropped or in-flight update finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (beats_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input int lo, input int hi);
    for (int j = 0; j < NUM_JOINTS_DEF; j++)
      write_reg(CFG_IDX_GEAR0 + CFG_IDX_W'(j), CFG_DATA_W'($urandom_range(lo, hi)));
    // upper data bits are don't-care for the mask register
    write_reg(CFG_IDX_MASK, CFG_DATA_W'($urandom));
  endtask

  task automatic send_random_update(output bit framed);
    logic [JOINT_W-1:0]        joint;
    logic signed [SPEED_W-1:0] speed;
    logic signed [ANGLE_W-1:0] angle;
    if ($urandom_range(0, 19) == 0)
      joint = JOINT_W'($urandom_range(NUM_JOINTS_DEF, 7));
    else
      joint = JOINT_W'($urandom_range(0, NUM_JOINTS_DEF - 1));
    case ($urandom_range(0, 3))
      0: speed = SPEED_W'($urandom);
      1: speed = SPEED_W'($urandom_range(0, 2000));
      2: speed = SPEED_W'($urandom & ((32'd1 << $urandom_range(1, 23)) - 1));
      default: speed = ($urandom_range(0, 3) == 0) ? '0 : SPEED_W'($urandom_range(600, 800));
    endcase
    if ($urandom_range(0, 1)) speed = -speed;
    case ($urandom_range(0, 3))
      0: angle = ANGLE_W'($urandom);
      1: angle = sent_angle[joint];
      default: angle = sent_angle[joint] + ANGLE_W'($urandom_range(0, 200) - 100);
    endcase
    send_update(joint, speed, angle);
    framed = (joint < NUM_JOINTS_DEF);
  endtask

  task automatic random_phase(input int count, input int hold_at, input int pause_at);
    int  sent;
    bit  framed;
    sent = 0;
    while (sent < count) begin
      send_random_update(framed);
      if (framed) sent++;
      if (sent == hold_at && framed) hold_reqs++;
      if (sent == pause_at && framed) begin
        // sender waits for the whole backlog before going on
        in_valid <= 1'b0;
        do @(negedge clk); while (beats_pending != 0);
        @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    for (int j = 0; j < 8; j++) sent_angle[j] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: unit gears, mask 3
    send_update(3'd0, 24'sd0, 24'sd100);          // first update, zero speed
    send_update(3'd0, 24'sd1, 24'sd100);          // same angle, period saturates high
    send_update(3'd0, 24'sh7FFFFF, 24'sh7FFFFF);  // largest positive speed, quotient 5
    send_update(3'd0, 24'sh800000, 24'sh800000);  // most negative speed and angle
    send_update(3'd1, 24'sd687, -24'sd5);         // just above 65535
    send_update(3'd1, -24'sd688, -24'sd5);        // largest in-range period
    send_update(3'd1, -24'sd1, 24'sh7FFFFF);
    send_update(3'd2, 24'sd1000, 24'sd0);
    send_update(3'd2, -24'sd1000, -24'sd1);
    send_update(3'd3, 24'sh555555, 24'sd123);
    send_update(3'd4, 24'shAAAAAA, -24'sd123);
    send_update(3'd5, 24'sd45, 24'sd7);           // sixth joint gets a frame too
    send_update(3'd6, 24'sd100, 24'sd5);          // out-of-range joints: no frame
    send_update(3'd7, 24'sd100, 24'sd5);
    send_update(3'd5, 24'sd700, 24'sd6);
    drain();

    // gear extremes, zero gear on joint 1, mask cleared via masked-off data bits
    write_reg(CFG_IDX_GEAR0 + 3'd0, 12'd4095);
    write_reg(CFG_IDX_GEAR0 + 3'd1, 12'd0);
    write_reg(CFG_IDX_GEAR0 + 3'd2, 12'd1);
    write_reg(CFG_IDX_GEAR0 + 3'd3, 12'd4095);
    write_reg(CFG_IDX_GEAR0 + 3'd4, 12'd2);
    write_reg(CFG_IDX_GEAR0 + 3'd5, 12'd4095);
    write_reg(CFG_IDX_MASK, 12'hFC0);
    write_reg(CFG_IDX_UNUSED, 12'hFFF);
    for (int j = 0; j < NUM_JOINTS_DEF; j++)
      send_update(JOINT_W'(j), 24'sd10997, sent_angle[j] + 24'sd1);
    drain();
    write_reg(CFG_IDX_MASK, 12'd63);
    for (int j = 0; j < NUM_JOINTS_DEF; j++)
      send_update(JOINT_W'(j), -24'sd10998, sent_angle[j] - 24'sd1);
    drain();

    load_config(1, 4095);
    random_phase(70, 10, 40);
    load_config(1, 8);
    random_phase(70, -1, -1);
    load_config(0, 4095);
    random_phase(60, -1, -1);
    idle_on = 1'b0;
    load_config(1, 64);
    random_phase(60, -1, -1);

    if (fail_count == 0 && beats_pending == 0)
      $display("PASS joint_step_period_frame_encoder_unit");
    else
      $display("FAIL joint_step_period_frame_encoder_unit");
    $finish;
  end

endmodule
